FILE: sv/assert_macros.svh
// Assertion helpers for the deframer. Every macro samples on clk_i and is
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("concurrent assertion failed");

`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("concurrent implication failed");

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

FILE: sv/mcrd_pkg.sv
`timescale 1ns / 1ps

package mcrd_pkg;

  localparam int unsigned QDEPTH = 2;

  localparam logic [8:0]  HEADER_LEN    = 9'd3;
  localparam logic [8:0]  MIN_FRAME_LEN = 9'd5;
  localparam logic [8:0]  CARD_FIRST    = 9'd4;
  localparam logic [8:0]  CARD_LAST     = 9'd6;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;

  localparam logic [1:0] CARD_NONE = 2'd3;

  typedef enum logic [2:0] {
    KIND_ADDR,
    KIND_FUNC,
    KIND_LEN,
    KIND_PAYLOAD,
    KIND_CRC_LO,
    KIND_CRC_HI,
    KIND_SHORT
  } kind_e;

  // One classified byte handed from the front end to the back end.
  typedef struct packed {
    kind_e      kind;
    logic [1:0] card_sel;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/mcrd_front.sv
`timescale 1ns / 1ps

module mcrd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [7:0]      s_tdata_i,
  input  logic            s_tuser_i,
  input  mcrd_pkg::q_stat_t q_stat_i,
  output logic            push_o,
  output mcrd_pkg::cmd_t  cmd_o
);
  import mcrd_pkg::*;

  logic [8:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [8:0] crc_end;
  logic       accept;

  assign s_tready_o = !q_stat_i.full;
  assign accept     = s_tvalid_i && s_tready_o;
  assign crc_end    = HEADER_LEN + {1'b0, len_q};

  always_comb begin
    cmd_o.data     = s_tdata_i;
    cmd_o.card_sel = CARD_NONE;
    if (s_tuser_i) begin
      cmd_o.kind = KIND_SHORT;
    end else if (pos_q == 9'd0) begin
      cmd_o.kind = KIND_ADDR;
    end else if (pos_q == 9'd1) begin
      cmd_o.kind = KIND_FUNC;
    end else if (pos_q == 9'd2) begin
      cmd_o.kind = KIND_LEN;
    end else if (pos_q < crc_end) begin
      cmd_o.kind = KIND_PAYLOAD;
      if (pos_q >= CARD_FIRST && pos_q <= CARD_LAST) begin
        cmd_o.card_sel = 2'(pos_q - CARD_FIRST);
      end
    end else if (pos_q == crc_end) begin
      cmd_o.kind = KIND_CRC_LO;
    end else begin
      cmd_o.kind = KIND_CRC_HI;
    end
  end

  // A gap between frames carries no work for the back end.
  assign push_o = accept && !(s_tuser_i && pos_q == 9'd0);

  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    if (accept) begin
      if (cmd_o.kind == KIND_SHORT || cmd_o.kind == KIND_CRC_HI) begin
        pos_d = 9'd0;
        len_d = 8'd0;
      end else begin
        pos_d = pos_q + 9'd1;
        if (cmd_o.kind == KIND_LEN) begin
          len_d = s_tdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 9'd0;
      len_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
    end
  end

endmodule

FILE: sv/mcrd_queue.sv
`timescale 1ns / 1ps

module mcrd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mcrd_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output mcrd_pkg::cmd_t    head_o,
  output mcrd_pkg::q_stat_t stat_o
);
  import mcrd_pkg::*;

  localparam int unsigned PtrW = $clog2(QDEPTH);

  cmd_t            mem_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == (PtrW+1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule

FILE: sv/mcrd_back.sv
`timescale 1ns / 1ps

module mcrd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcrd_pkg::cmd_t    head_i,
  input  mcrd_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [55:0]       m_tdata_o,
  output logic [1:0]        m_tuser_o
);
  import mcrd_pkg::*;

  logic [7:0]  addr_q, func_q, len_q, crc_lo_q;
  logic [15:0] crc_q;
  logic [23:0] card_q;
  logic        m_valid_q;
  logic [1:0]  o_status_q;
  logic [7:0]  o_addr_q, o_func_q;
  logic [23:0] o_card_q;
  logic [8:0]  o_used_q;
  logic        is_result, out_free, crc_match;

  assign is_result = (head_i.kind == KIND_CRC_HI) || (head_i.kind == KIND_SHORT);
  assign out_free  = !m_valid_q || m_tready_i;
  assign pop_o     = !q_stat_i.empty && (!is_result || out_free);
  assign crc_match = ({head_i.data, crc_lo_q} == crc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= 8'd0;
      func_q   <= 8'd0;
      len_q    <= 8'd0;
      crc_lo_q <= 8'd0;
      crc_q    <= CRC_INIT;
      card_q   <= 24'd0;
    end else if (pop_o) begin
      case (head_i.kind)
        KIND_ADDR: begin
          addr_q <= head_i.data;
          crc_q  <= crc_update(crc_q, head_i.data);
        end
        KIND_FUNC: begin
          func_q <= head_i.data;
          crc_q  <= crc_update(crc_q, head_i.data);
        end
        KIND_LEN: begin
          len_q <= head_i.data;
          crc_q <= crc_update(crc_q, head_i.data);
        end
        KIND_PAYLOAD: begin
          crc_q <= crc_update(crc_q, head_i.data);
          case (head_i.card_sel)
            2'd0:    card_q[7:0]   <= card_q[7:0]   | head_i.data;
            2'd1:    card_q[15:8]  <= card_q[15:8]  | head_i.data;
            2'd2:    card_q[23:16] <= card_q[23:16] | head_i.data;
            default: card_q        <= card_q;
          endcase
        end
        KIND_CRC_LO: begin
          crc_lo_q <= head_i.data;
        end
        default: begin
          // End of frame, either complete or cut short by a gap.
          addr_q   <= 8'd0;
          func_q   <= 8'd0;
          len_q    <= 8'd0;
          crc_lo_q <= 8'd0;
          crc_q    <= CRC_INIT;
          card_q   <= 24'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (pop_o && is_result) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_result) begin
      if (head_i.kind == KIND_SHORT) begin
        o_status_q <= ST_SHORT;
        o_addr_q   <= 8'd0;
        o_func_q   <= 8'd0;
        o_card_q   <= 24'd0;
        o_used_q   <= 9'd0;
      end else if (crc_match) begin
        o_status_q <= ST_OK;
        o_addr_q   <= addr_q;
        o_func_q   <= func_q;
        o_card_q   <= card_q;
        o_used_q   <= MIN_FRAME_LEN + {1'b0, len_q};
      end else begin
        o_status_q <= ST_MISMATCH;
        o_addr_q   <= addr_q;
        o_func_q   <= func_q;
        o_card_q   <= 24'd0;
        o_used_q   <= HEADER_LEN;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = o_status_q;
  assign m_tdata_o  = {7'd0, o_used_q, o_card_q, o_func_q, o_addr_q};

endmodule

FILE: sv/modbus_card_response_deframer.sv
`timescale 1ns / 1ps
// Modbus RTU response deframer: takes one received byte per request on the slave
// side (tuser high marks an idle gap) and returns one result per complete or
// broken frame on the master side, with the header address and function code,
// the 24-bit card number from frame bytes 4 to 6 and the byte count consumed.
// It takes one byte every cycle while the queue has room; the bound is the
// back end's byte-wide CRC-16/MODBUS update, done once per cycle. A result
// is registered on the master side once the byte that ends its frame has left
// the queue and the output register is free. A two-entry queue sits between
// the byte classifier and the CRC and result stage, so a stalled master side
// stops input only once the queue and the output register are full.
`include "assert_macros.svh"

module modbus_card_response_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,  // [7:0] rx_byte
  input  logic        s_tuser_i,  // [0] gap
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [55:0] m_tdata_o,  // [7:0] node_addr, [15:8] function_code,
                                  // [39:16] card_id, [48:40] consumed
  output logic [1:0]  m_tuser_o   // [1:0] status
);
  import mcrd_pkg::*;

  cmd_t    push_cmd, head_cmd;
  q_stat_t q_stat;
  logic    push, pop;

  mcrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mcrd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  mcrd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  `ASSERT_CLK(a_queue_sane, !(q_stat.full && q_stat.empty))
  `ASSERT_IMPL(a_short_zero, m_tvalid_o && m_tuser_o == ST_SHORT, m_tdata_o == 56'd0)
  `ASSERT_IMPL(a_mismatch_fields, m_tvalid_o && m_tuser_o == ST_MISMATCH,
               m_tdata_o[48:40] == HEADER_LEN && m_tdata_o[39:16] == 24'd0)
  `ASSERT_IMPL(a_ok_len, m_tvalid_o && m_tuser_o == ST_OK,
               m_tdata_o[48:40] >= MIN_FRAME_LEN)

endmodule

FILE: tb/sv/modbus_card_response_deframer_tb.sv
`timescale 1ns / 1ps

module modbus_card_response_deframer_tb;
  import mcrd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned BYTE_TARGET  = 1200;
  localparam int unsigned IDLE_PCT     = 24;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [23:0] card;
    logic [8:0]  consumed;
  } frame_result_t;

  // Scoreboard: tracks the frame parser state and holds the results still owed.
  class deframe_scoreboard;
    frame_result_t expected_frames[$];
    int unsigned   errors;
    logic [8:0]    byte_count;
    logic [7:0]    hdr_addr;
    logic [7:0]    hdr_func;
    logic [7:0]    pay_len;
    logic [15:0]   crc;
    logic [7:0]    crc_lo;
    logic [23:0]   card;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    function void clear_frame();
      byte_count = '0;
      hdr_addr   = '0;
      hdr_func   = '0;
      pay_len    = '0;
      crc        = CRC_INIT;
      crc_lo     = '0;
      card       = '0;
    endfunction

    function void push_result(logic [1:0] st, logic [7:0] a, logic [7:0] f,
                              logic [23:0] c, logic [8:0] n);
      frame_result_t r;
      r.status   = st;
      r.addr     = a;
      r.func     = f;
      r.card     = c;
      r.consumed = n;
      expected_frames.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b, logic gap);
      logic [8:0] crc_end;
      crc_end = HEADER_LEN + {1'b0, pay_len};
      if (gap) begin
        // A gap only produces a result when it cuts a frame short.
        if (byte_count != '0) begin
          push_result(ST_SHORT, 8'h00, 8'h00, 24'h0, 9'd0);
        end
        clear_frame();
      end else if (byte_count < HEADER_LEN) begin
        if (byte_count == 9'd0) begin
          hdr_addr = b;
        end else if (byte_count == 9'd1) begin
          hdr_func = b;
        end else begin
          pay_len = b;
        end
        crc = crc_step(crc, b);
        byte_count++;
      end else if (byte_count < crc_end) begin
        if (byte_count >= CARD_FIRST && byte_count <= CARD_LAST) begin
          card[8 * int'(byte_count - CARD_FIRST) +: 8] = b;
        end
        crc = crc_step(crc, b);
        byte_count++;
      end else if (byte_count == crc_end) begin
        crc_lo = b;
        byte_count++;
      end else begin
        if ({b, crc_lo} == crc) begin
          push_result(ST_OK, hdr_addr, hdr_func, card, MIN_FRAME_LEN + {1'b0, pay_len});
        end else begin
          push_result(ST_MISMATCH, hdr_addr, hdr_func, 24'h0, HEADER_LEN);
        end
        clear_frame();
      end
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [55:0] data, logic [1:0] user);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result", {user, data}, 0);
      end else begin
        want = expected_frames.pop_front();
        if (user != want.status) report_mismatch("status", user, want.status);
        if (data[7:0] != want.addr) report_mismatch("node_addr", data[7:0], want.addr);
        if (data[15:8] != want.func) report_mismatch("function_code", data[15:8], want.func);
        if (data[39:16] != want.card) report_mismatch("card_id", data[39:16], want.card);
        if (data[48:40] != want.consumed) begin
          report_mismatch("consumed", data[48:40], want.consumed);
        end
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = 8'h00;
  logic        s_tuser_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [55:0] m_tdata_o;
  logic [1:0]  m_tuser_o;

  deframe_scoreboard sb = new();
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  modbus_card_response_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL modbus_card_response_deframer");
      $finish;
    end
  end

  // Result side: random backpressure outside the steady window, checked at every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      sb.check_result(m_tdata_o, m_tuser_o);
    end
    m_tready_i <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_request(input logic [7:0] b, input logic gap);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tuser_i  <= gap;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_byte(b, gap);
    bytes_sent++;
    steady = (bytes_sent >= 500 && bytes_sent < 800);
  endtask

  // Sends one frame with random payload; cut_at >= 0 breaks it with a gap
  // after that many bytes.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] len, input bit good_crc, input int cut_at);
    logic [7:0]  frame_bytes[$];
    logic [15:0] fcs;
    frame_bytes = {addr, func, len};
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    fcs = CRC_INIT;
    foreach (frame_bytes[i]) fcs = deframe_scoreboard::crc_step(fcs, frame_bytes[i]);
    if (!good_crc) fcs ^= 16'($urandom_range(1, 16'hFFFF));
    frame_bytes.push_back(fcs[7:0]);
    frame_bytes.push_back(fcs[15:8]);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (cut_at >= 0 && i == cut_at) break;
      send_request(frame_bytes[i], 1'b0);
    end
    if (cut_at >= 0) send_request(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] pick_len(int unsigned frame_no);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (frame_no == 5) return 8'd255;
    if (r < 2) return 8'($urandom_range(200, 255));
    if (r < 10) return 8'($urandom_range(9, 40));
    return 8'($urandom_range(0, 8));
  endfunction

  initial begin
    int unsigned frame_no;
    int unsigned r;
    logic [7:0]  len;
    int          n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle gap, back-to-back frames (good, good with card bytes,
    // bad checksum), and a frame cut short by a gap.
    send_request(8'hFF, 1'b1);
    send_frame(8'h00, 8'hFF, 8'd0, 1'b1, -1);
    send_frame(8'hFF, 8'h00, 8'd4, 1'b1, -1);
    send_frame(8'hA5, 8'h5A, 8'd1, 1'b0, -1);
    send_frame(8'h11, 8'h03, 8'd3, 1'b1, 2);

    frame_no = 0;
    while (bytes_sent < BYTE_TARGET) begin
      r = $urandom_range(0, 99);
      len = pick_len(frame_no);
      if (r < 70) begin
        send_frame(8'($urandom), 8'($urandom), len, $urandom_range(0, 99) < 85, -1);
      end else if (r < 85) begin
        send_frame(8'($urandom), 8'($urandom), len, 1'b1,
                   $urandom_range(1, 4 + int'(len)));
      end else if (r < 95) begin
        // Noise; left without a gap it misaligns the next frame.
        n = $urandom_range(1, 6);
        repeat (n) send_request(8'($urandom), 1'b0);
        if ($urandom_range(0, 99) < 70) send_request(8'($urandom), 1'b1);
      end else begin
        send_request(8'($urandom), 1'b1);
      end
      if ($urandom_range(0, 99) < 20) send_request(8'($urandom), 1'b1);
      frame_no++;
    end
    s_tvalid_i <= 1'b0;

    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS modbus_card_response_deframer");
    end else begin
      $display("FAIL modbus_card_response_deframer");
    end
    $finish;
  end

endmodule
